// ----- design/ltl_pkg.sv -----
// Shared types, token codes and character tables for the lifetime token lexer.
package ltl_pkg;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [15:0] bytes;
        logic [15:0] line;
    } t_token;

    localparam logic [3:0] KIND_LANGLE    = 4'd0;
    localparam logic [3:0] KIND_RANGLE    = 4'd1;
    localparam logic [3:0] KIND_LIFETIME  = 4'd3;
    localparam logic [3:0] KIND_STATIC    = 4'd4;
    localparam logic [3:0] KIND_ANON      = 4'd5;
    localparam logic [3:0] KIND_COLON     = 4'd6;
    localparam logic [3:0] KIND_COMMA     = 4'd7;
    localparam logic [3:0] KIND_PLUS      = 4'd8;
    localparam logic [3:0] KIND_AMP       = 4'd9;
    localparam logic [3:0] KIND_MUT       = 4'd10;
    localparam logic [3:0] KIND_IDENT     = 4'd11;
    localparam logic [3:0] KIND_END       = 4'd13;
    localparam logic [3:0] KIND_INVALID   = 4'd14;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] LEAD_LO  = 8'hD8;
    localparam logic [7:0] LEAD_HI  = 8'hDB;
    localparam logic [7:0] STRAY_LO = 8'hDC;

    // Keyword slots: 0 "mut", 1 Arabic mut, 2 "'static", 3 Arabic static
    localparam logic [3:0] KW_LEN [4] = '{4'd3, 4'd10, 4'd7, 4'd9};

    function automatic logic [7:0] kw_byte(logic [1:0] k, logic [3:0] i);
        logic [7:0] r;
        r = 8'h00;
        unique case (k)
            2'd0: begin
                unique case (i)
                    4'd0: r = 8'h6D;
                    4'd1: r = 8'h75;
                    4'd2: r = 8'h74;
                    default: r = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (i)
                    4'd0: r = 8'hD9;
                    4'd1: r = 8'h85;
                    4'd2: r = 8'hD8;
                    4'd3: r = 8'hAA;
                    4'd4: r = 8'hD8;
                    4'd5: r = 8'hBA;
                    4'd6: r = 8'hD9;
                    4'd7: r = 8'h8A;
                    4'd8: r = 8'hD8;
                    4'd9: r = 8'hB1;
                    default: r = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (i)
                    4'd0: r = 8'h27;
                    4'd1: r = 8'h73;
                    4'd2: r = 8'h74;
                    4'd3: r = 8'h61;
                    4'd4: r = 8'h74;
                    4'd5: r = 8'h69;
                    4'd6: r = 8'h63;
                    default: r = 8'h00;
                endcase
            end
            default: begin
                unique case (i)
                    4'd0: r = 8'h27;
                    4'd1: r = 8'hD8;
                    4'd2: r = 8'hAB;
                    4'd3: r = 8'hD8;
                    4'd4: r = 8'hA7;
                    4'd5: r = 8'hD8;
                    4'd6: r = 8'hA8;
                    4'd7: r = 8'hD8;
                    4'd8: r = 8'hAA;
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_word(logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER;
    endfunction

    function automatic logic is_lead(logic [7:0] b);
        return b >= LEAD_LO && b <= LEAD_HI;
    endfunction

endpackage

// ----- design/lifetime_token_lexer_top.sv -----
// Streaming lexer for lifetime annotations: one source byte in, up to three tokens out.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+--------------------------------------------------
//  input   | i_valid | o_ready | i_source_byte, i_final_byte
//  output  | o_valid | i_ready | o_token_kind, o_token_start, o_token_bytes,
//          |         |         | o_token_line, o_run_last
//
// One byte is taken per cycle while o_ready is high; its tokens appear in the result buffer the next cycle.
// A byte that yields more than one token holds the input off while the buffer drains
// one token per cycle when i_ready is high, until its last token goes out.
// Reset (synchronous, active low) empties the buffer and returns the scanner to idle.
// A stalled output keeps the buffer full and drops o_ready until the last token goes.
module lifetime_token_lexer_top
    import ltl_pkg::*;
#(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_source_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [31:0] o_token_start,
    output logic [15:0] o_token_bytes,
    output logic [15:0] o_token_line,
    output logic        o_run_last
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_APOS,
        MODE_IDENT,
        MODE_LIFE_WORD,
        MODE_LIFE_ASCII
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    t_mode                   r_mode,   n_mode;
    logic                    r_pair,   n_pair;
    logic [OFFSET_BITS-1:0]  r_pstart, n_pstart;
    logic [LENGTH_BITS-1:0]  r_plen,   n_plen;
    logic [LINE_BITS-1:0]    r_pline,  n_pline;
    logic [3:0]              r_alive,  n_alive;
    logic [OFFSET_BITS-1:0]  r_offset, n_offset;
    logic [LINE_BITS-1:0]    r_line,   n_line;

    t_token                  r_slot [3];
    t_token                  n_slot [3];
    logic [1:0]              r_cnt,    n_cnt;

    logic                    accept;
    logic                    drain;

    function automatic logic [3:0] f_keep(logic [3:0] a, logic [LENGTH_BITS-1:0] len,
                                          logic [7:0] b);
        logic [3:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            r[k] = a[k] && (len < LENGTH_BITS'(KW_LEN[k])) &&
                   (kw_byte(2'(k), len[3:0]) == b);
        end
        return r;
    endfunction

    function automatic logic f_hit(logic [3:0] a, logic [LENGTH_BITS-1:0] len, int k);
        return a[k] && (len == LENGTH_BITS'(KW_LEN[k]));
    endfunction

    function automatic t_token f_tok(logic [3:0] kind, logic [OFFSET_BITS-1:0] start,
                                     logic [LENGTH_BITS-1:0] len,
                                     logic [LINE_BITS-1:0] line);
        t_token t;
        t.kind  = kind;
        t.start = 32'(start);
        t.bytes = 16'(len);
        t.line  = 16'(line);
        return t;
    endfunction

    assign o_ready = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);
    assign accept  = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign drain   = o_valid && i_ready;

    assign o_token_kind  = r_slot[0].kind;
    assign o_token_start = r_slot[0].start;
    assign o_token_bytes = r_slot[0].bytes;
    assign o_token_line  = r_slot[0].line;
    assign o_run_last    = (r_cnt == 2'd1);

    always_comb begin
        logic [7:0]  b;
        logic        handled;
        logic        newline;
        logic        do_take;
        logic        pend_emit;
        logic [3:0]  pend_kind;
        t_token      e_tok;

        b         = i_source_byte;
        handled   = 1'b0;
        newline   = (b == CH_LF);
        do_take   = 1'b0;
        pend_emit = 1'b0;
        pend_kind = KIND_INVALID;
        e_tok     = '0;

        n_mode   = r_mode;
        n_pair   = r_pair;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_pline  = r_pline;
        n_alive  = r_alive;
        n_offset = r_offset;
        n_line   = r_line;
        n_cnt    = 2'd0;
        for (int s = 0; s < 3; s++) begin
            n_slot[s] = '0;
        end

        // Decide what the pending token does with this byte
        unique case (r_mode)
            MODE_APOS: begin
                if (b == CH_UNDER) begin
                    do_take   = 1'b1;
                    pend_emit = 1'b1;
                    pend_kind = KIND_ANON;
                    handled   = 1'b1;
                end else if (is_lead(b)) begin
                    do_take = 1'b1;
                    n_mode  = MODE_LIFE_WORD;
                    n_pair  = 1'b1;
                    handled = 1'b1;
                end else if (b >= STRAY_LO) begin
                    pend_emit = 1'b1;
                    pend_kind = KIND_LIFETIME;
                end else if (is_alpha(b)) begin
                    do_take = 1'b1;
                    n_mode  = MODE_LIFE_ASCII;
                    handled = 1'b1;
                end else begin
                    pend_emit = 1'b1;
                    pend_kind = KIND_INVALID;
                end
            end
            MODE_IDENT, MODE_LIFE_WORD: begin
                if (r_pair) begin
                    do_take = 1'b1;
                    n_pair  = 1'b0;
                    newline = 1'b0;
                    handled = 1'b1;
                end else if (is_lead(b)) begin
                    do_take = 1'b1;
                    n_pair  = 1'b1;
                    handled = 1'b1;
                end else if (is_word(b)) begin
                    do_take = 1'b1;
                    handled = 1'b1;
                end else begin
                    pend_emit = 1'b1;
                    if (r_mode == MODE_IDENT) begin
                        pend_kind = (f_hit(r_alive, r_plen, 0) || f_hit(r_alive, r_plen, 1))
                                    ? KIND_MUT : KIND_IDENT;
                    end else begin
                        pend_kind = (f_hit(r_alive, r_plen, 2) || f_hit(r_alive, r_plen, 3))
                                    ? KIND_STATIC : KIND_LIFETIME;
                    end
                end
            end
            MODE_LIFE_ASCII: begin
                if (is_word(b)) begin
                    do_take = 1'b1;
                    handled = 1'b1;
                end else begin
                    pend_emit = 1'b1;
                    pend_kind = (f_hit(r_alive, r_plen, 2) || f_hit(r_alive, r_plen, 3))
                                ? KIND_STATIC : KIND_LIFETIME;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        // Extend the pending token by this byte
        if (do_take) begin
            n_alive = f_keep(r_alive, r_plen, b);
            n_plen  = (r_plen == LENGTH_MAX) ? r_plen : r_plen + LENGTH_BITS'(1);
        end

        // Close the pending token and hand it out
        if (pend_emit) begin
            e_tok = f_tok(pend_kind, r_pstart, n_plen, r_pline);
            n_slot[n_cnt] = e_tok;
            n_cnt  = n_cnt + 2'd1;
            n_mode = MODE_IDLE;
            n_pair = 1'b0;
        end

        // Scan the byte from idle
        if (!handled) begin
            unique case (b)
                CH_LT, CH_GT, CH_COLON, CH_COMMA, CH_PLUS, CH_AMP: begin
                    unique case (b)
                        CH_LT:    e_tok.kind = KIND_LANGLE;
                        CH_GT:    e_tok.kind = KIND_RANGLE;
                        CH_COLON: e_tok.kind = KIND_COLON;
                        CH_COMMA: e_tok.kind = KIND_COMMA;
                        CH_PLUS:  e_tok.kind = KIND_PLUS;
                        default:  e_tok.kind = KIND_AMP;
                    endcase
                    e_tok = f_tok(e_tok.kind, r_offset, LENGTH_BITS'(1), r_line);
                    if (n_cnt < 2'd3) begin
                        n_slot[n_cnt] = e_tok;
                        n_cnt = n_cnt + 2'd1;
                    end
                end
                CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                end
                default: begin
                    if (b == CH_APOS || is_lead(b) || is_alpha(b) || b == CH_UNDER) begin
                        n_pstart = r_offset;
                        n_pline  = r_line;
                        n_plen   = LENGTH_BITS'(1);
                        n_alive  = f_keep(4'hF, '0, b);
                        n_pair   = is_lead(b);
                        n_mode   = (b == CH_APOS) ? MODE_APOS : MODE_IDENT;
                    end else begin
                        e_tok = f_tok(KIND_INVALID, r_offset, LENGTH_BITS'(1), r_line);
                        if (n_cnt < 2'd3) begin
                            n_slot[n_cnt] = e_tok;
                            n_cnt = n_cnt + 2'd1;
                        end
                    end
                end
            endcase
        end

        if (newline) begin
            n_line = (r_line == LINE_MAX) ? r_line : r_line + LINE_BITS'(1);
        end
        n_offset = (r_offset == OFFSET_MAX) ? r_offset : r_offset + OFFSET_BITS'(1);

        // Last byte: flush, add the end token, start over
        if (i_final_byte) begin
            pend_emit = 1'b1;
            unique case (n_mode)
                MODE_APOS:  pend_kind = KIND_INVALID;
                MODE_IDENT: pend_kind = (f_hit(n_alive, n_plen, 0) ||
                                         f_hit(n_alive, n_plen, 1)) ? KIND_MUT : KIND_IDENT;
                MODE_LIFE_WORD, MODE_LIFE_ASCII:
                            pend_kind = (f_hit(n_alive, n_plen, 2) ||
                                         f_hit(n_alive, n_plen, 3)) ? KIND_STATIC
                                                                    : KIND_LIFETIME;
                default: begin
                    pend_emit = 1'b0;
                    pend_kind = KIND_INVALID;
                end
            endcase
            if (pend_emit && n_cnt < 2'd3) begin
                n_slot[n_cnt] = f_tok(pend_kind, n_pstart, n_plen, n_pline);
                n_cnt = n_cnt + 2'd1;
            end
            if (n_cnt < 2'd3) begin
                n_slot[n_cnt] = f_tok(KIND_END, n_offset, '0, n_line);
                n_cnt = n_cnt + 2'd1;
            end
            n_mode   = MODE_IDLE;
            n_pair   = 1'b0;
            n_pstart = '0;
            n_plen   = '0;
            n_pline  = LINE_BITS'(1);
            n_alive  = 4'hF;
            n_offset = '0;
            n_line   = LINE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pair   <= 1'b0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_pline  <= LINE_BITS'(1);
            r_alive  <= 4'hF;
            r_offset <= '0;
            r_line   <= LINE_BITS'(1);
            r_cnt    <= 2'd0;
        end else begin
            if (accept) begin
                r_mode   <= n_mode;
                r_pair   <= n_pair;
                r_pstart <= n_pstart;
                r_plen   <= n_plen;
                r_pline  <= n_pline;
                r_alive  <= n_alive;
                r_offset <= n_offset;
                r_line   <= n_line;
                r_cnt    <= n_cnt;
            end else if (drain) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Result buffer: load a fresh run, or shift the next token to the head
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int s = 0; s < 3; s++) begin
                r_slot[s] <= n_slot[s];
            end
        end else if (drain) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_final_byte |=>
            o_valid && r_mode == MODE_IDLE && r_offset == '0)
        else $error("final byte did not restart the scanner with tokens pending");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == KIND_END |-> o_run_last)
        else $error("end token is not the last token of its run");

    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_pline != '0)
        else $error("line counter reached zero");

    a_no_empty_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid && drain && r_cnt == 2'd1 |=> !o_valid)
        else $error("result buffer did not empty after its last token");

endmodule

// ----- sim/lifetime_token_lexer_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the lifetime token lexer: directed and random source text.
module lifetime_token_lexer_top_test
    import ltl_pkg::*;
();

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BYTES = 100;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [7:0] KW_TEXT [4][10] = '{
        '{8'h6D, 8'h75, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hD9, 8'h85, 8'hD8, 8'hAA, 8'hD8, 8'hBA, 8'hD9, 8'h8A, 8'hD8, 8'hB1},
        '{8'h27, 8'h73, 8'h74, 8'h61, 8'h74, 8'h69, 8'h63, 8'h00, 8'h00, 8'h00},
        '{8'h27, 8'hD8, 8'hAB, 8'hD8, 8'hA7, 8'hD8, 8'hA8, 8'hD8, 8'hAA, 8'h00}
    };
    localparam int KW_SIZE [4] = '{3, 10, 7, 9};
    localparam logic [7:0] PUNCT [6] = '{CH_LT, CH_GT, CH_COLON, CH_COMMA, CH_PLUS, CH_AMP};
    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

    // Every token kind but mut and static, lifetime forms, stray bytes, lead pair swallowing a newline,
    // apostrophe on the last byte.
    localparam int DIRECTED_COUNT = 26;
    localparam logic [7:0] DIRECTED [DIRECTED_COUNT] = '{
        CH_LT, CH_GT, CH_COLON, CH_COMMA, CH_PLUS, CH_AMP, CH_SPACE, CH_TAB, CH_CR,
        CH_APOS, CH_UNDER, CH_APOS, 8'h61, 8'h39, 8'hDC, CH_APOS, 8'hDC, CH_APOS, 8'h21,
        8'hD8, CH_LF, 8'h80, 8'hFF, 8'h00, CH_LF, CH_APOS
    };

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_APOS, SCAN_IDENT, SCAN_LIFE_WORD, SCAN_LIFE_ASCII
    } t_scan;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } t_lex_token;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } t_src_byte;

    class t_token_checker;
        t_scan       mode;
        bit          pair_open;
        logic [31:0] tok_start;
        logic [15:0] tok_len;
        logic [15:0] tok_line;
        logic [3:0]  kw_live;
        logic [31:0] offset;
        logic [15:0] line_no;
        t_lex_token  step_q[$];
        t_lex_token  tokens_due[$];
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            mode = SCAN_IDLE;
            pair_open = 0;
            tok_start = '0;
            tok_len = '0;
            tok_line = 16'd1;
            kw_live = 4'hF;
            offset = '0;
            line_no = 16'd1;
        endfunction

        function logic [15:0] bump16(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function bit is_letter(logic [7:0] b);
            return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
        endfunction

        function bit is_word_char(logic [7:0] b);
            return is_letter(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_UNDER;
        endfunction

        function bit is_lead_byte(logic [7:0] b);
            return b >= LEAD_LO && b <= LEAD_HI;
        endfunction

        function void add_token(logic [3:0] kind, logic [31:0] start, logic [15:0] len,
                                logic [15:0] line);
            t_lex_token t;
            if (step_q.size() < 3) begin
                t = '{kind, start, len, line, 1'b0};
                step_q.insert(step_q.size(), t);
            end
        endfunction

        // Advance the pending token and drop keywords that no longer match.
        function void take_byte(logic [7:0] b);
            for (int k = 0; k < 4; k++) begin
                if (!(kw_live[k] && tok_len < KW_SIZE[k] && KW_TEXT[k][tok_len] == b))
                    kw_live[k] = 1'b0;
            end
            tok_len = bump16(tok_len);
        endfunction

        function void open_token(logic [7:0] b, t_scan m);
            tok_start = offset;
            tok_line = line_no;
            tok_len = '0;
            kw_live = 4'hF;
            pair_open = 0;
            mode = m;
            take_byte(b);
        endfunction

        function bit kw_match(int k);
            return kw_live[k] && tok_len == KW_SIZE[k];
        endfunction

        function void close_token(logic [3:0] kind);
            add_token(kind, tok_start, tok_len, tok_line);
            mode = SCAN_IDLE;
            pair_open = 0;
        endfunction

        function void flush_token();
            case (mode)
                SCAN_APOS: close_token(KIND_INVALID);
                SCAN_IDENT: close_token((kw_match(0) || kw_match(1)) ? KIND_MUT : KIND_IDENT);
                SCAN_LIFE_WORD, SCAN_LIFE_ASCII:
                    close_token((kw_match(2) || kw_match(3)) ? KIND_STATIC : KIND_LIFETIME);
                default: mode = SCAN_IDLE;
            endcase
        endfunction

        function void idle_byte(logic [7:0] b);
            logic [3:0] kind;
            case (b)
                CH_LT: kind = KIND_LANGLE;
                CH_GT: kind = KIND_RANGLE;
                CH_COLON: kind = KIND_COLON;
                CH_COMMA: kind = KIND_COMMA;
                CH_PLUS: kind = KIND_PLUS;
                CH_AMP: kind = KIND_AMP;
                CH_APOS: begin
                    open_token(b, SCAN_APOS);
                    return;
                end
                CH_SPACE, CH_TAB, CH_LF, CH_CR: return;
                default: begin
                    if (is_lead_byte(b)) begin
                        open_token(b, SCAN_IDENT);
                        pair_open = 1;
                    end else if (is_letter(b) || b == CH_UNDER) begin
                        open_token(b, SCAN_IDENT);
                    end else begin
                        add_token(KIND_INVALID, offset, 16'd1, line_no);
                    end
                    return;
                end
            endcase
            add_token(kind, offset, 16'd1, line_no);
        endfunction

        function void accept_byte(logic [7:0] b, logic fin);
            bit handled;
            bit nl;
            handled = 0;
            nl = (b == CH_LF);
            step_q.delete();
            case (mode)
                SCAN_APOS: begin
                    if (b == CH_UNDER) begin
                        take_byte(b);
                        close_token(KIND_ANON);
                        handled = 1;
                    end else if (is_lead_byte(b)) begin
                        take_byte(b);
                        mode = SCAN_LIFE_WORD;
                        pair_open = 1;
                        handled = 1;
                    end else if (b >= STRAY_LO) begin
                        close_token(KIND_LIFETIME);
                    end else if (is_letter(b)) begin
                        take_byte(b);
                        mode = SCAN_LIFE_ASCII;
                        handled = 1;
                    end else begin
                        close_token(KIND_INVALID);
                    end
                end
                SCAN_IDENT, SCAN_LIFE_WORD: begin
                    if (pair_open) begin
                        // second byte of a pair is taken whatever it is, newline too
                        take_byte(b);
                        pair_open = 0;
                        nl = 0;
                        handled = 1;
                    end else if (is_lead_byte(b)) begin
                        take_byte(b);
                        pair_open = 1;
                        handled = 1;
                    end else if (is_word_char(b)) begin
                        take_byte(b);
                        handled = 1;
                    end else begin
                        flush_token();
                    end
                end
                SCAN_LIFE_ASCII: begin
                    if (is_word_char(b)) begin
                        take_byte(b);
                        handled = 1;
                    end else begin
                        flush_token();
                    end
                end
                default: mode = SCAN_IDLE;
            endcase
            if (!handled)
                idle_byte(b);
            if (nl)
                line_no = bump16(line_no);
            if (offset != 32'hFFFF_FFFF)
                offset = offset + 32'd1;
            if (fin) begin
                flush_token();
                add_token(KIND_END, offset, 16'd0, line_no);
                restart();
            end
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            foreach (step_q[i])
                tokens_due.insert(tokens_due.size(), step_q[i]);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t mismatch: %s", $realtime, what);
        endtask

        task check_token(logic [3:0] kind, logic [31:0] start, logic [15:0] len,
                         logic [15:0] line, logic last);
            t_lex_token want;
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf("token kind %0d start %0d with none expected",
                                          kind, start));
                return;
            end
            want = tokens_due.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (start !== want.start)
                report_mismatch($sformatf("start %0d, expected %0d", start, want.start));
            if (len !== want.len)
                report_mismatch($sformatf("length %0d, expected %0d", len, want.len));
            if (line !== want.line)
                report_mismatch($sformatf("line %0d, expected %0d", line, want.line));
            if (last !== want.last)
                report_mismatch($sformatf("run_last %0b, expected %0b", last, want.last));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_source_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_token_kind;
    logic [31:0] o_token_start;
    logic [15:0] o_token_bytes;
    logic [15:0] o_token_line;
    logic        o_run_last;

    t_token_checker tracker;
    t_src_byte      text_q[$];
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_left;
    int             quiet_cycles;

    lifetime_token_lexer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_source_byte (i_source_byte),
        .i_final_byte  (i_final_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_token_kind  (o_token_kind),
        .o_token_start (o_token_start),
        .o_token_bytes (o_token_bytes),
        .o_token_line  (o_token_line),
        .o_run_last    (o_run_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                tracker.accept_byte(i_source_byte, i_final_byte);
            if (o_valid && i_ready)
                tracker.check_token(o_token_kind, o_token_start, o_token_bytes,
                                    o_token_line, o_run_last);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [7:0] pick_word_char();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(8'h61, 8'h7A));
            1: return 8'($urandom_range(8'h41, 8'h5A));
            2: return 8'($urandom_range(8'h30, 8'h39));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic void push_byte(logic [7:0] b);
        t_src_byte s;
        s = '{b, 1'b0};
        text_q.insert(text_q.size(), s);
    endfunction

    // Lead byte plus a second byte, usually a proper continuation byte.
    function automatic void push_lead_pair();
        push_byte(8'($urandom_range(LEAD_LO, LEAD_HI)));
        if ($urandom_range(9) != 0)
            push_byte(8'($urandom_range(8'h80, 8'hBF)));
        else
            push_byte(8'($urandom_range(0, 255)));
    endfunction

    function automatic void push_fragment();
        int k;
        case ($urandom_range(0, 9))
            0: push_byte(PUNCT[$urandom_range(0, 5)]);
            1: push_byte(BLANKS[$urandom_range(0, 3)]);
            2: begin
                k = $urandom_range(0, 3);
                for (int i = 0; i < KW_SIZE[k]; i++)
                    push_byte(KW_TEXT[k][i]);
            end
            3, 4: begin
                if ($urandom_range(3) == 0)
                    push_lead_pair();
                else
                    push_byte($urandom_range(1) ? 8'($urandom_range(8'h61, 8'h7A))
                                                : CH_UNDER);
                repeat ($urandom_range(0, 5)) begin
                    if ($urandom_range(3) == 0)
                        push_lead_pair();
                    else
                        push_byte(pick_word_char());
                end
            end
            5: begin
                push_byte(CH_APOS);
                push_byte(8'($urandom_range(8'h41, 8'h5A)) | ($urandom_range(1) ? 8'h20 : 8'h00));
                repeat ($urandom_range(0, 4))
                    push_byte(pick_word_char());
            end
            6: begin
                push_byte(CH_APOS);
                push_lead_pair();
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(1))
                        push_lead_pair();
                    else
                        push_byte(pick_word_char());
                end
            end
            7: begin
                push_byte(CH_APOS);
                push_byte(CH_UNDER);
            end
            8: push_byte(8'($urandom_range(0, 255)));
            default: begin
                if ($urandom_range(1))
                    push_lead_pair();
                else
                    push_byte(8'($urandom_range(STRAY_LO, 8'hFF)));
            end
        endcase
        // mostly separate tokens, sometimes let them run together
        if ($urandom_range(9) < 6)
            push_byte($urandom_range(1) ? BLANKS[$urandom_range(0, 3)]
                                        : PUNCT[$urandom_range(0, 5)]);
    endfunction

    function automatic void push_source();
        int first;
        int span;
        first = text_q.size();
        span = $urandom_range(3, 30);
        while (text_q.size() - first < span)
            push_fragment();
        text_q[text_q.size() - 1].fin = 1'b1;
    endfunction

    task send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_source_byte = b;
        i_final_byte = fin;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_source_byte = 8'h00;
        i_final_byte = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            text_q.delete();
            if (ph == 0) begin
                foreach (DIRECTED[i])
                    push_byte(DIRECTED[i]);
                text_q[text_q.size() - 1].fin = 1'b1;
                for (int i = 0; i < KW_SIZE[0]; i++)
                    push_byte(KW_TEXT[0][i]);
                text_q[text_q.size() - 1].fin = 1'b1;
                push_byte(LEAD_HI);
                text_q[text_q.size() - 1].fin = 1'b1;
            end
            while (text_q.size() < PHASE_BYTES + (ph == 0 ? DIRECTED_COUNT + 4 : 0))
                push_source();
            foreach (text_q[i]) begin
                // stall the output while the sender keeps pushing, so the block backs up
                if (ph == 0 && i == DIRECTED_COUNT + 4)
                    hold_left = HOLD_CYCLES;
                send_byte(text_q[i].data, text_q[i].fin);
            end
            i_valid = 1'b0;
            while (tracker.tokens_due.size() != 0)
                @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.tokens_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
